// ----- rtl/core/assert_macros.svh -----
// assertion macros shared by the filter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property checked on every rising edge outside reset
`define CAF_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

// property checked on every rising edge, reset included
`define CAF_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`else

`define CAF_ASSERT(label, clk, rstn, prop)
`define CAF_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ----- rtl/core/caf_pkg.sv -----
// shared types and constants of the prefix allow/deny filter
package caf_pkg;

    localparam int ALLOW_ENTRIES = 16;
    localparam int DENY_ENTRIES  = 16;

    localparam int ADDR_W   = 128;
    localparam int HALF_W   = 64;
    localparam int LEN_W    = 8;
    localparam int CODE_W   = 10;
    localparam int S_DATA_W = 136;
    localparam int S_USER_W = 3;
    localparam int M_DATA_W = 16;

    localparam logic [LEN_W-1:0]  V4_BITS     = 8'd32;
    localparam logic [LEN_W-1:0]  V6_BITS     = 8'd128;
    localparam logic [CODE_W-1:0] CODE_RESET  = 10'd403;
    localparam logic [ADDR_W-1:0] ADDR_ONES   = {ADDR_W{1'b1}};

    typedef enum logic [1:0] {
        MODE_ADD_ALLOW = 2'd0,
        MODE_ADD_DENY  = 2'd1,
        MODE_CLEAR     = 2'd2,
        MODE_CHECK     = 2'd3
    } mode_t;

    // one stored prefix: mask is precomputed at load time
    typedef struct packed {
        logic              valid;
        logic              is_ipv6;
        logic              len_ok;
        logic [ADDR_W-1:0] mask;
        logic [ADDR_W-1:0] addr;
    } entry_t;

    // controls broadcast to every cell of a row
    typedef struct packed {
        logic shift_en;
        logic clear;
        logic check_en;
    } cell_ctrl_t;

endpackage

// ----- rtl/core/caf_cell.sv -----
// one prefix cell: holds an entry, passes it on when the row shifts, compares it
`include "assert_macros.svh"

module caf_cell (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  caf_pkg::cell_ctrl_t         ctrl,
    input  caf_pkg::entry_t             entry_in,
    output caf_pkg::entry_t             entry_out,
    input  logic [caf_pkg::ADDR_W-1:0]  client_addr,
    input  logic                        client_ipv6,
    output logic                        match
);

    logic                        valid_reg;
    logic                        valid_next;
    logic                        is_ipv6_reg;
    logic                        len_ok_reg;
    logic [caf_pkg::ADDR_W-1:0]  mask_reg;
    logic [caf_pkg::ADDR_W-1:0]  addr_reg;
    logic                        match_reg;
    logic                        match_next;

    always_comb begin
        valid_next = valid_reg;
        if (ctrl.clear) begin
            valid_next = 1'b0;
        end else if (ctrl.shift_en) begin
            valid_next = entry_in.valid;
        end
    end

    assign match_next = valid_reg && len_ok_reg && (is_ipv6_reg == client_ipv6) &&
                        (((addr_reg ^ client_addr) & mask_reg) == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (ctrl.check_en) begin
                match_reg <= match_next;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (ctrl.shift_en) begin
            is_ipv6_reg <= entry_in.is_ipv6;
            len_ok_reg  <= entry_in.len_ok;
            mask_reg    <= entry_in.mask;
            addr_reg    <= entry_in.addr;
        end
    end

    assign entry_out.valid   = valid_reg;
    assign entry_out.is_ipv6 = is_ipv6_reg;
    assign entry_out.len_ok  = len_ok_reg;
    assign entry_out.mask    = mask_reg;
    assign entry_out.addr    = addr_reg;
    assign match             = match_reg;

    `CAF_ASSERT(a_clear_empties, aclk, aresetn, ctrl.clear |=> !valid_reg)
    `CAF_ASSERT(a_shift_moves_valid, aclk, aresetn,
        (ctrl.shift_en && !ctrl.clear) |=> (valid_reg == $past(entry_in.valid)))
    `CAF_ASSERT(a_idle_holds_valid, aclk, aresetn,
        (!ctrl.shift_en && !ctrl.clear) |=> $stable(valid_reg))

endmodule

// ----- rtl/core/cidr_allow_deny_filter.sv -----
// top level of the prefix allow/deny filter: cell rows, control and output register
// Prefix allow/deny filter. Two rows of cells hold up to 16 allow and 16 deny
// prefixes (IPv4 or IPv6, left-aligned in 128 bits). A load beat shifts a new
// entry into cell 0 of its row; a full row drops the load and returns one
// result beat with table_full set. A clear beat empties both rows and resets
// the sticky overflow flag. A check beat is compared against every cell in
// parallel in the cycle it is accepted; the per-cell hits are registered in
// the cells and reduced into the output register once it is free, which
// raises m_tvalid. A check or a dropped load holds s_tready low until its
// result moves into the output register, which waits while an earlier result
// waits on m_tready. So the input side takes no new beat until such a beat's
// result has moved on; loads that fit and clears go at one per cycle while no
// result is pending. If the allow row holds any entry the client is denied
// unless an allow entry matches, otherwise it is denied only if a deny entry
// matches. denied_code (reset 403) is written through cfg_we/cfg_wdata; the
// user must write it only while the block is idle; the block itself does not
// enforce this.
`include "assert_macros.svh"

module cidr_allow_deny_filter (
    input  logic                            aclk,
    input  logic                            aresetn,
    // config register denied_code
    input  logic                            cfg_we,
    input  logic [caf_pkg::CODE_W-1:0]      cfg_wdata,
    // input channel
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [63:0] address_high, [127:64] address_low, [135:128] prefix_length
    input  logic [caf_pkg::S_DATA_W-1:0]    s_tdata,
    // [1:0] mode, [2] is_ipv6
    input  logic [caf_pkg::S_USER_W-1:0]    s_tuser,
    // result channel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [0] denied, [10:1] response_status, [11] table_full, [15:12] zero
    output logic [caf_pkg::M_DATA_W-1:0]    m_tdata
);

    // input unpacking
    caf_pkg::mode_t                   s_mode;
    logic                             s_ipv6;
    logic [caf_pkg::ADDR_W-1:0]       s_addr;
    logic [caf_pkg::LEN_W-1:0]        s_len;

    assign s_mode = caf_pkg::mode_t'(s_tuser[1:0]);
    assign s_ipv6 = s_tuser[2];
    // high half sits in the upper address bits
    assign s_addr = {s_tdata[63:0], s_tdata[127:64]};
    assign s_len  = s_tdata[135:128];

    logic accept;
    assign accept = s_tvalid && s_tready;

    // new entry built at the head of both rows
    caf_pkg::entry_t new_entry;
    assign new_entry.valid   = 1'b1;
    assign new_entry.is_ipv6 = s_ipv6;
    assign new_entry.len_ok  = s_ipv6 ? (s_len <= caf_pkg::V6_BITS)
                                      : (s_len <= caf_pkg::V4_BITS);
    // shifts of 128 or more give an all-ones mask; lengths above 128 never match anyway
    assign new_entry.mask    = ~(caf_pkg::ADDR_ONES >> s_len);
    assign new_entry.addr    = s_addr;

    // cell rows
    caf_pkg::entry_t                  allow_ent [caf_pkg::ALLOW_ENTRIES];
    caf_pkg::entry_t                  deny_ent  [caf_pkg::DENY_ENTRIES];
    logic [caf_pkg::ALLOW_ENTRIES-1:0] allow_match;
    logic [caf_pkg::DENY_ENTRIES-1:0]  deny_match;
    logic [caf_pkg::ALLOW_ENTRIES-1:0] allow_valid;
    caf_pkg::cell_ctrl_t              allow_ctrl;
    caf_pkg::cell_ctrl_t              deny_ctrl;

    // rows fill from cell 0, so the last cell tells when a row is full
    logic allow_full;
    logic deny_full;
    assign allow_full = allow_ent[caf_pkg::ALLOW_ENTRIES-1].valid;
    assign deny_full  = deny_ent[caf_pkg::DENY_ENTRIES-1].valid;

    logic is_check;
    logic is_clear;
    logic drop_load;

    always_comb begin
        is_check  = 1'b0;
        is_clear  = 1'b0;
        drop_load = 1'b0;
        unique case (s_mode)
            caf_pkg::MODE_ADD_ALLOW: drop_load = allow_full;
            caf_pkg::MODE_ADD_DENY:  drop_load = deny_full;
            caf_pkg::MODE_CLEAR:     is_clear  = 1'b1;
            caf_pkg::MODE_CHECK:     is_check  = 1'b1;
            default:                 is_check  = 1'b0;
        endcase
    end

    assign allow_ctrl.shift_en = accept && (s_mode == caf_pkg::MODE_ADD_ALLOW) && !allow_full;
    assign allow_ctrl.clear    = accept && is_clear;
    assign allow_ctrl.check_en = accept && is_check;
    assign deny_ctrl.shift_en  = accept && (s_mode == caf_pkg::MODE_ADD_DENY) && !deny_full;
    assign deny_ctrl.clear     = accept && is_clear;
    assign deny_ctrl.check_en  = accept && is_check;

    for (genvar i = 0; i < caf_pkg::ALLOW_ENTRIES; i++) begin : g_allow
        caf_pkg::entry_t cell_in;
        if (i == 0) begin : g_head
            assign cell_in = new_entry;
        end else begin : g_link
            assign cell_in = allow_ent[i-1];
        end
        caf_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (allow_ctrl),
            .entry_in    (cell_in),
            .entry_out   (allow_ent[i]),
            .client_addr (s_addr),
            .client_ipv6 (s_ipv6),
            .match       (allow_match[i])
        );
        assign allow_valid[i] = allow_ent[i].valid;
    end

    for (genvar i = 0; i < caf_pkg::DENY_ENTRIES; i++) begin : g_deny
        caf_pkg::entry_t cell_in;
        if (i == 0) begin : g_head
            assign cell_in = new_entry;
        end else begin : g_link
            assign cell_in = deny_ent[i-1];
        end
        caf_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (deny_ctrl),
            .entry_in    (cell_in),
            .entry_out   (deny_ent[i]),
            .client_addr (s_addr),
            .client_ipv6 (s_ipv6),
            .match       (deny_match[i])
        );
    end

    // config and sticky overflow
    logic [caf_pkg::CODE_W-1:0] code_reg;
    logic                       overflow_reg;
    logic                       overflow_next;

    always_comb begin
        overflow_next = overflow_reg;
        if (accept && is_clear) begin
            overflow_next = 1'b0;
        end else if (accept && drop_load) begin
            overflow_next = 1'b1;
        end
    end

    // pending result: a check waiting for its reduction, or a dropped load
    logic pend_reg;
    logic pend_next;
    logic pend_check_reg;
    logic pend_full_reg;
    logic out_load;

    assign out_load = pend_reg && (!m_tvalid || m_tready);
    assign s_tready = !pend_reg;

    always_comb begin
        pend_next = pend_reg;
        if (accept && (is_check || drop_load)) begin
            pend_next = 1'b1;
        end else if (out_load) begin
            pend_next = 1'b0;
        end
    end

    // result reduction
    logic                        res_denied;
    logic [caf_pkg::M_DATA_W-1:0] res_data;

    always_comb begin
        res_denied = 1'b0;
        if (pend_check_reg) begin
            // rows are stable while a result is pending
            res_denied = allow_ent[0].valid ? !(|allow_match) : (|deny_match);
        end
        res_data = {4'b0000, pend_full_reg,
                    (res_denied ? code_reg : {caf_pkg::CODE_W{1'b0}}), res_denied};
    end

    // output register
    logic                         m_valid_reg;
    logic                         m_valid_next;
    logic [caf_pkg::M_DATA_W-1:0] m_data_reg;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            code_reg     <= caf_pkg::CODE_RESET;
            overflow_reg <= 1'b0;
            pend_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                code_reg <= cfg_wdata;
            end
            overflow_reg <= overflow_next;
            pend_reg     <= pend_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (accept && (is_check || drop_load)) begin
            pend_check_reg <= is_check;
            // a dropped load reports the flag it just set
            pend_full_reg  <= is_check ? overflow_reg : 1'b1;
        end
        if (out_load) begin
            m_data_reg <= res_data;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // allow row valid bits always form a run starting at cell 0
    logic [caf_pkg::ALLOW_ENTRIES-1:0] allow_valid_inc;
    assign allow_valid_inc = (caf_pkg::ALLOW_ENTRIES)'(allow_valid + 1'b1);

    `CAF_ASSERT(a_allow_contiguous, aclk, aresetn, (allow_valid & allow_valid_inc) == '0)
    `CAF_ASSERT(a_result_drains, aclk, aresetn, out_load |=> !pend_reg)
    `CAF_ASSERT(a_drop_gives_result, aclk, aresetn,
        (accept && drop_load) |=> (pend_reg && pend_full_reg && overflow_reg))
    `CAF_ASSERT(a_check_takes_flag, aclk, aresetn,
        (accept && is_check) |=> (pend_check_reg && (pend_full_reg == overflow_reg)))

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// self-checking bench for the prefix allow/deny filter: directed cases, table overflow, status codes, random traffic
module tb_top;
    import caf_pkg::*;

    localparam int CLK_HALF      = 6;
    // loads that fit and clears give nothing back, so this many quiet cycles
    // covers anything still moving through the rows
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 20000;

    // one stored prefix as the bench sees it, address left-aligned in 128 bits
    typedef struct {
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  plen;
        logic              v6;
    } prefix_rule_t;

    // one result beat: denied flag, status code, sticky drop flag
    typedef struct packed {
        logic              denied;
        logic [CODE_W-1:0] status;
        logic              full;
    } verdict_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [CODE_W-1:0]   cfg_wdata = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    // [63:0] address_high, [127:64] address_low, [135:128] prefix_length
    logic [S_DATA_W-1:0] s_tdata   = '0;
    // [1:0] mode, [2] is_ipv6
    logic [S_USER_W-1:0] s_tuser   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    // [0] denied, [10:1] response_status, [11] table_full, [15:12] zero
    logic [M_DATA_W-1:0] m_tdata;

    // bench copy of the filter state
    prefix_rule_t      allow_rules[$];
    prefix_rule_t      deny_rules[$];
    logic              drop_seen   = 1'b0;
    logic [CODE_W-1:0] status_code = CODE_RESET;
    verdict_t          pending_verdicts[$];

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned items_sent     = 0;
    int unsigned failures       = 0;

    cidr_allow_deny_filter u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #CLK_HALF aclk = ~aclk;

    // result side back-pressure, percentage set per phase
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic void log_failure(string what);
        failures++;
        if (failures <= 10) begin
            $display("mismatch %0d at %0t: %s", failures, $time, what);
        end
    endfunction

    // a prefix matches when the family agrees, the length is legal for the
    // family and the leading plen bits agree; plen 0 matches every address of that family
    function automatic bit rule_covers(prefix_rule_t r, logic v6, logic [ADDR_W-1:0] addr);
        logic [ADDR_W-1:0] keep;
        keep = ~(ADDR_ONES >> r.plen);
        if (r.v6 != v6) return 1'b0;
        if (r.plen > (r.v6 ? V6_BITS : V4_BITS)) return 1'b0;
        return ((r.addr ^ addr) & keep) == '0;
    endfunction

    // advance the bench state by one accepted beat and queue what it should return
    function automatic void filter_apply(mode_t mode, logic v6, logic [ADDR_W-1:0] addr,
                                         logic [LEN_W-1:0] plen);
        prefix_rule_t r;
        verdict_t     v;
        bit           hit;
        r.addr = addr;
        r.plen = plen;
        r.v6   = v6;
        hit    = 1'b0;
        case (mode)
            MODE_ADD_ALLOW, MODE_ADD_DENY: begin
                if (mode == MODE_ADD_ALLOW && allow_rules.size() < ALLOW_ENTRIES) begin
                    allow_rules.push_back(r);
                end else if (mode == MODE_ADD_DENY && deny_rules.size() < DENY_ENTRIES) begin
                    deny_rules.push_back(r);
                end else begin
                    // row full: load dropped, one beat back with table_full
                    drop_seen = 1'b1;
                    v.denied  = 1'b0;
                    v.status  = '0;
                    v.full    = 1'b1;
                    pending_verdicts.push_back(v);
                end
            end
            MODE_CLEAR: begin
                allow_rules.delete();
                deny_rules.delete();
                drop_seen = 1'b0;
            end
            default: begin
                // any allow entry turns the filter into a whitelist
                if (allow_rules.size() != 0) begin
                    foreach (allow_rules[i]) if (rule_covers(allow_rules[i], v6, addr)) hit = 1'b1;
                    v.denied = !hit;
                end else begin
                    foreach (deny_rules[i]) if (rule_covers(deny_rules[i], v6, addr)) hit = 1'b1;
                    v.denied = hit;
                end
                v.status = v.denied ? status_code : '0;
                v.full   = drop_seen;
                pending_verdicts.push_back(v);
            end
        endcase
    endfunction

    // every result beat is held against the oldest queued verdict
    always @(posedge aclk) begin : result_check
        verdict_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_verdicts.size() == 0) begin
                log_failure($sformatf("result beat %h with nothing pending", m_tdata));
            end else begin
                want = pending_verdicts.pop_front();
                if (m_tdata[0] !== want.denied || m_tdata[10:1] !== want.status ||
                        m_tdata[11] !== want.full) begin
                    log_failure($sformatf(
                        "denied %0b/%0b status %0d/%0d table_full %0b/%0b (expected/actual)",
                        want.denied, m_tdata[0], want.status, m_tdata[10:1],
                        want.full, m_tdata[11]));
                end
            end
        end
    end

    // one input beat with a random lead-in gap; returns once the beat is taken
    task automatic send_item(mode_t mode, logic v6, logic [ADDR_W-1:0] addr,
                             logic [LEN_W-1:0] plen);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {v6, mode};
        s_tdata  <= {plen, addr[HALF_W-1:0], addr[ADDR_W-1:HALF_W]};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        filter_apply(mode, v6, addr, plen);
        items_sent++;
    endtask

    // stop sending, wait for every queued verdict, then let the rows settle
    task automatic drain_pipeline();
        int unsigned waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (pending_verdicts.size() != 0) begin
            log_failure($sformatf("%0d result beats never arrived", pending_verdicts.size()));
            pending_verdicts.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_status_code(logic [CODE_W-1:0] code);
        cfg_we    <= 1'b1;
        cfg_wdata <= code;
        @(posedge aclk);
        cfg_we      <= 1'b0;
        status_code = code;
    endtask

    function automatic logic [ADDR_W-1:0] v4_addr(logic [31:0] a);
        return {a, 96'h0};
    endfunction

    // ipv4 mostly with clean spare bits, now and then with garbage below bit 96
    function automatic logic [ADDR_W-1:0] random_address(logic v6);
        if (v6 || $urandom_range(7) == 0) begin
            return {$urandom, $urandom, $urandom, $urandom};
        end
        return {$urandom, 96'h0};
    endfunction

    // lengths lean on the edges, with the odd too-long ipv4 prefix
    function automatic logic [LEN_W-1:0] random_plen(logic v6);
        int unsigned pick;
        pick = $urandom_range(19);
        if (pick == 0) return v6 ? V6_BITS : LEN_W'($urandom_range(128, 33));
        if (pick < 4) begin
            case ($urandom_range(2))
                0:       return '0;
                1:       return v6 ? LEN_W'(64) : V4_BITS;
                default: return v6 ? V6_BITS : LEN_W'($urandom_range(31, 1));
            endcase
        end
        return v6 ? LEN_W'($urandom_range(128)) : LEN_W'($urandom_range(32));
    endfunction

    task automatic send_rule(mode_t mode);
        logic v6;
        v6 = $urandom_range(1);
        send_item(mode, v6, random_address(v6), random_plen(v6));
    endtask

    // probe derived from a stored prefix: exact hit, a flip inside the prefix,
    // a flip past it, a family swap or new ipv4 spare bits; otherwise a random client
    task automatic send_probe();
        prefix_rule_t      r;
        logic [ADDR_W-1:0] addr;
        logic              v6;
        int unsigned       lim;
        int unsigned       pos;
        if (allow_rules.size() + deny_rules.size() != 0 && $urandom_range(3) != 0) begin
            if (deny_rules.size() == 0 || (allow_rules.size() != 0 && $urandom_range(1))) begin
                r = allow_rules[$urandom_range(allow_rules.size() - 1)];
            end else begin
                r = deny_rules[$urandom_range(deny_rules.size() - 1)];
            end
            addr = r.addr;
            v6   = r.v6;
            lim  = v6 ? 128 : 32;
            case ($urandom_range(3))
                0: ;
                1: if (r.plen != 0 && r.plen <= lim) begin
                    pos = $urandom_range(r.plen - 1);
                    addr[ADDR_W-1-pos] = ~addr[ADDR_W-1-pos];
                end
                2: if (r.plen < lim) begin
                    pos = $urandom_range(lim - 1, r.plen);
                    addr[ADDR_W-1-pos] = ~addr[ADDR_W-1-pos];
                end
                default: if ($urandom_range(3) == 0) begin
                    v6 = ~v6;
                end else if (!v6) begin
                    addr[95:0] = {$urandom, $urandom, $urandom};
                end
            endcase
        end else begin
            v6   = $urandom_range(1);
            addr = random_address(v6);
        end
        send_item(MODE_CHECK, v6, addr, LEN_W'($urandom_range(128)));
    endtask

    // row sizes: often empty, mostly a few, sometimes enough to overflow
    function automatic int unsigned pick_row_fill();
        int unsigned pick;
        pick = $urandom_range(19);
        if (pick < 8) return 0;
        if (pick < 17) return $urandom_range(5, 1);
        return $urandom_range(19, 14);
    endfunction

    // clear (usually), load both rows interleaved, then a run of checks
    task automatic policy_round();
        int unsigned n_allow;
        int unsigned n_deny;
        if ($urandom_range(3) != 0) begin
            send_item(MODE_CLEAR, $urandom_range(1), random_address(1'b1),
                      LEN_W'($urandom_range(128)));
        end
        n_allow = pick_row_fill();
        n_deny  = pick_row_fill();
        while (n_allow + n_deny != 0) begin
            if (n_allow != 0 && (n_deny == 0 || $urandom_range(1))) begin
                send_rule(MODE_ADD_ALLOW);
                n_allow--;
            end else begin
                send_rule(MODE_ADD_DENY);
                n_deny--;
            end
        end
        repeat ($urandom_range(12, 3)) send_probe();
    endtask

    // fully random beats, any mode
    task automatic noise_burst();
        repeat ($urandom_range(4, 1)) begin
            send_item(mode_t'($urandom_range(3)), $urandom_range(1),
                      {$urandom, $urandom, $urandom, $urandom}, LEN_W'($urandom_range(128)));
        end
    endtask

    task automatic test_empty_tables();
        send_item(MODE_CHECK, 1'b0, v4_addr(32'h0), '0);
        send_item(MODE_CHECK, 1'b1, ADDR_ONES, V6_BITS);
    endtask

    // deny row only; reset status code shows up here
    task automatic test_deny_prefixes();
        send_item(MODE_ADD_DENY, 1'b0, v4_addr(32'h0A00_0000), 8'd8);
        send_item(MODE_CHECK, 1'b0, v4_addr(32'h0A01_0203), V6_BITS);
        // spare bits under an ipv4 address never take part
        send_item(MODE_CHECK, 1'b0, {32'h0A01_0203, {96{1'b1}}}, 8'd0);
        // same bits, other family
        send_item(MODE_CHECK, 1'b1, v4_addr(32'h0A01_0203), 8'd0);
        send_item(MODE_ADD_DENY, 1'b0, {32'hC0A8_0001, 32'h1234_5678, 64'h0}, V4_BITS);
        send_item(MODE_CHECK, 1'b0, v4_addr(32'hC0A8_0001), 8'd0);
        // ipv4 prefix longer than 32 is stored but never hits
        send_item(MODE_ADD_DENY, 1'b0, v4_addr(32'hAC10_0000), 8'd33);
        send_item(MODE_CHECK, 1'b0, v4_addr(32'hAC10_0000), 8'd0);
        // zero-length prefix covers the whole family
        send_item(MODE_ADD_DENY, 1'b1, ADDR_ONES, 8'd0);
        send_item(MODE_CHECK, 1'b1, '0, 8'd0);
        send_item(MODE_CLEAR, 1'b0, '0, 8'd0);
        send_item(MODE_CHECK, 1'b1, '0, 8'd0);
    endtask

    task automatic test_allow_prefixes();
        // /65 splits at the top bit of the low half
        send_item(MODE_ADD_ALLOW, 1'b1, {64'h2001_0DB8_0000_0000, 64'h0}, 8'd65);
        send_item(MODE_CHECK, 1'b1, {64'h2001_0DB8_0000_0000, 64'h8000_0000_0000_0000}, 8'd0);
        send_item(MODE_CHECK, 1'b1, {64'h2001_0DB8_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF}, 8'd0);
        send_item(MODE_ADD_ALLOW, 1'b1, ADDR_ONES, V6_BITS);
        send_item(MODE_CHECK, 1'b1, ADDR_ONES, 8'd0);
        send_item(MODE_CHECK, 1'b1, ADDR_ONES ^ ADDR_W'(1), 8'd0);
        send_item(MODE_CHECK, 1'b0, v4_addr(32'h0), 8'd0);
        // deny row is ignored while the allow row holds anything
        send_item(MODE_ADD_DENY, 1'b0, v4_addr(32'h0), 8'd0);
        send_item(MODE_ADD_ALLOW, 1'b0, v4_addr(32'h0), 8'd0);
        send_item(MODE_CHECK, 1'b0, v4_addr(32'hFFFF_FFFF), 8'd0);
        send_item(MODE_CLEAR, 1'b1, ADDR_ONES, V6_BITS);
    endtask

    // fill each row past capacity, flag stays until the next clear
    task automatic test_table_overflow();
        repeat (ALLOW_ENTRIES + 1) send_rule(MODE_ADD_ALLOW);
        send_probe();
        repeat (DENY_ENTRIES + 2) send_rule(MODE_ADD_DENY);
        send_probe();
        send_item(MODE_CLEAR, 1'b0, '0, 8'd0);
        send_probe();
    endtask

    task automatic test_status_codes();
        logic [CODE_W-1:0] codes[4];
        codes = '{10'd0, 10'd999, 10'd1023, CODE_W'($urandom_range(998, 1))};
        foreach (codes[i]) begin
            drain_pipeline();
            write_status_code(codes[i]);
            send_item(MODE_CLEAR, 1'b0, '0, 8'd0);
            send_item(MODE_ADD_DENY, 1'b1, random_address(1'b1), 8'd0);
            send_item(MODE_CHECK, 1'b1, random_address(1'b1), 8'd0);
            send_item(MODE_CHECK, 1'b0, random_address(1'b0), 8'd0);
        end
    endtask

    // random rounds under one idle setting, with one full stop halfway
    task automatic test_random_traffic(int unsigned budget, int unsigned send_pct,
                                       int unsigned recv_pct, logic [CODE_W-1:0] code);
        int unsigned target;
        int unsigned halfway;
        bit          paused;
        drain_pipeline();
        write_status_code(code);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        target  = items_sent + budget;
        halfway = items_sent + budget / 2;
        paused  = 1'b0;
        while (items_sent < target) begin
            if (!paused && items_sent >= halfway) begin
                drain_pipeline();
                paused = 1'b1;
            end
            if ($urandom_range(9) != 0) begin
                policy_round();
            end else begin
                noise_burst();
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_idle_pct  = 26;
        recv_stall_pct = 77;
        test_empty_tables();
        test_deny_prefixes();
        test_allow_prefixes();
        test_table_overflow();
        test_status_codes();
        test_random_traffic(650, 26, 77, 10'd999);
        test_random_traffic(650, 77, 26, CODE_W'($urandom_range(1023)));
        test_random_traffic(650, 0, 0, CODE_RESET);
        drain_pipeline();
        if (failures == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
